### src/bicubic_image_resizer_macros.svh
`ifndef BICUBIC_IMAGE_RESIZER_MACROS_SVH
`define BICUBIC_IMAGE_RESIZER_MACROS_SVH

// same-cycle implication
`define BIR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bir_pkg;

    typedef struct packed {
        logic       mode;
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
    } bir_item_t;

    typedef struct packed {
        logic [11:0] out_col;
        logic [11:0] out_row;
        logic [7:0]  blue_out;
        logic [7:0]  green_out;
        logic [7:0]  red_out;
    } bir_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRD_LOAD,
        ST_CRD_DIV,
        ST_CRD_END,
        ST_KER_SQR,
        ST_KER_MUL,
        ST_KER_RND,
        ST_TAP_MUL,
        ST_TAP_RND,
        ST_TAP_ACC,
        ST_FIN_LOAD,
        ST_FIN_DIV,
        ST_FIN_END,
        ST_DONE
    } bir_state_t;

    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

    localparam int unsigned DIV_NW = 38;
    localparam int unsigned DIV_DW = 32;
    localparam int unsigned DIV_CW = 6;
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_NW - 1);

    localparam int unsigned MUL_AW = 36;
    localparam int unsigned MUL_BW = 22;
    localparam int unsigned MUL_PW = 58;
    localparam int unsigned WT_W   = 18;

    // 4*one^3 and 12*one^3 in Q.48
    localparam logic signed [MUL_PW-1:0] KER_C_NEAR = 58'sd1125899906842624;
    localparam logic signed [MUL_PW-1:0] KER_C_FAR  = 58'sd3377699720527872;

endpackage

`default_nettype wire

### src/bicubic_image_resizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                       Payload
// item      start in, busy out              bir_item_t
// result    done out (one-cycle strobe)     bir_result_t
// config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// A pixel write (mode 0) is taken while idle and leaves busy low.
// A pixel request runs one shared 38-step restoring divider twice for the
// coordinates and three times for the normalisation, around 8 kernel weights
// and 16 tap weights formed on one shared multiplier.
// rst_n clears control and configuration; the image store holds no reset.
// The result is shown for one cycle and cannot be stalled.
module bicubic_image_resizer #(
    parameter int unsigned MAX_SRC_WIDTH  = 256,
    parameter int unsigned MAX_SRC_HEIGHT = 256,
    parameter int unsigned MAX_DST_DIM    = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bir_pkg::bir_item_t   item,
    output logic                 done,
    output bir_pkg::bir_result_t result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import bir_pkg::*;

    localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(MAX_SRC_WIDTH);
    localparam int unsigned RW    = $clog2(MAX_SRC_HEIGHT);

    bir_state_t state_reg, state_next;

    logic [8:0]  src_w_reg, src_h_reg;
    logic [12:0] dst_w_reg, dst_h_reg;
    logic [8:0]  sw, sh;
    logic [12:0] tw, th;
    logic        cfg_wr, accept, req_ok, wr_en;
    logic [AW-1:0] wr_addr, rd_addr;

    logic [23:0] mem [0:DEPTH-1];
    logic [23:0] rd_data_reg;

    logic [11:0] col_reg, row_reg;
    logic        axis_reg;
    logic [DIV_DW-1:0] div_rem_reg, div_den_reg;
    logic [DIV_NW-1:0] div_quo_reg;
    logic [DIV_CW-1:0] div_cnt_reg;
    logic [DIV_DW+1:0] div_diff;
    logic              div_ok;
    logic signed [9:0] base_x_reg, base_y_reg;
    logic [15:0]       u_x_reg, u_y_reg;
    logic [2:0]        k_reg;
    logic [3:0]        tap_reg;
    logic [1:0]        ch_reg;
    logic signed [MUL_PW-1:0] prod_reg;
    logic signed [WT_W-1:0]   wx_reg [4];
    logic signed [WT_W-1:0]   wy_reg [4];
    logic signed [WT_W-1:0]   w_reg;
    logic signed [31:0] acc_b_reg, acc_g_reg, acc_r_reg, acc_t_reg;
    logic [7:0] blue_reg, green_reg, red_reg;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;

    logic [11:0] dst_sel;
    logic [8:0]  sdim_sel;
    logic [12:0] ddim_sel;
    logic signed [25:0] crd_s;

    logic [15:0] u_sel;
    logic [17:0] kx;
    logic        k_near, k_zero;
    logic signed [MUL_BW-1:0] poly_a;
    logic signed [MUL_PW-1:0] w4;
    logic [MUL_PW-1:0]        w4_mag, w4_q;
    logic signed [WT_W-1:0]   k_weight;

    logic [MUL_PW-1:0]      tp_mag, tp_q;
    logic signed [WT_W-1:0] tap_w;

    logic signed [10:0] sx, sy, swd, shd;
    logic [8:0]  px, py;
    logic [11:0] px12, py12;
    logic signed [8:0] pb, pg, pr;

    logic signed [31:0] ch_sum, den_eff;
    logic [32:0]        ch_mag;
    logic [7:0]         ch_val;

    // configuration
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= 9'd256;
            src_h_reg <= 9'd256;
            dst_w_reg <= 13'd256;
            dst_h_reg <= 13'd256;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SOURCE_WIDTH:  src_w_reg <= pwdata[8:0];
                REG_SOURCE_HEIGHT: src_h_reg <= pwdata[8:0];
                REG_TARGET_WIDTH:  dst_w_reg <= pwdata[12:0];
                REG_TARGET_HEIGHT: dst_h_reg <= pwdata[12:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SOURCE_WIDTH:  prdata = {23'd0, src_w_reg};
            REG_SOURCE_HEIGHT: prdata = {23'd0, src_h_reg};
            REG_TARGET_WIDTH:  prdata = {19'd0, dst_w_reg};
            REG_TARGET_HEIGHT: prdata = {19'd0, dst_h_reg};
        endcase
    end

    always_comb
    begin
        sw = (src_w_reg == 9'd0) ? 9'd1 :
             (32'(src_w_reg) > MAX_SRC_WIDTH) ? 9'(MAX_SRC_WIDTH) : src_w_reg;
        sh = (src_h_reg == 9'd0) ? 9'd1 :
             (32'(src_h_reg) > MAX_SRC_HEIGHT) ? 9'(MAX_SRC_HEIGHT) : src_h_reg;
        tw = (dst_w_reg == 13'd0) ? 13'd1 :
             (32'(dst_w_reg) > MAX_DST_DIM) ? 13'(MAX_DST_DIM) : dst_w_reg;
        th = (dst_h_reg == 13'd0) ? 13'd1 :
             (32'(dst_h_reg) > MAX_DST_DIM) ? 13'(MAX_DST_DIM) : dst_h_reg;
    end

    assign accept = start & ~busy;
    assign req_ok = item.mode & ({1'b0, item.col} < tw) & ({1'b0, item.row} < th);
    assign wr_en  = accept & ~item.mode & (item.col < {3'd0, sw}) & (item.row < {3'd0, sh});
    assign wr_addr = AW'(item.row[RW-1:0] * MAX_SRC_WIDTH) + AW'(item.col[CW-1:0]);

    // image store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {item.red_in, item.green_in, item.blue_in};
        end
        if (state_reg == ST_TAP_MUL)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // shared multiplier
    assign dst_sel  = axis_reg ? row_reg : col_reg;
    assign sdim_sel = axis_reg ? sh : sw;
    assign ddim_sel = axis_reg ? th : tw;

    always_comb
    begin
        unique case (state_reg)
            ST_CRD_LOAD:
            begin
                mul_a = signed'(MUL_AW'({dst_sel, 1'b1}));
                mul_b = signed'(MUL_BW'(sdim_sel));
            end
            ST_KER_SQR:
            begin
                mul_a = signed'(MUL_AW'(kx));
                mul_b = signed'(MUL_BW'(kx));
            end
            ST_KER_MUL:
            begin
                mul_a = prod_reg[MUL_AW-1:0];
                mul_b = poly_a;
            end
            ST_TAP_MUL:
            begin
                mul_a = MUL_AW'(wx_reg[tap_reg[1:0]]);
                mul_b = MUL_BW'(wy_reg[tap_reg[3:2]]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divider step
    assign div_diff = {1'b0, div_rem_reg, div_quo_reg[DIV_NW-1]} - {2'b00, div_den_reg};
    assign div_ok   = ~div_diff[DIV_DW+1];

    assign crd_s = signed'({1'b0, div_quo_reg[24:0]}) - 26'sd32768;

    // kernel
    assign u_sel = k_reg[2] ? u_y_reg : u_x_reg;

    always_comb
    begin
        unique case (k_reg[1:0])
            2'd0: kx = 18'(u_sel) + 18'd65536;
            2'd1: kx = 18'(u_sel);
            2'd2: kx = 18'd65536 - 18'(u_sel);
            default: kx = 18'd131072 - 18'(u_sel);
        endcase
        k_near = (kx <= 18'd65536);
        k_zero = (kx >= 18'd131072);
        poly_a = k_near ? (signed'(MUL_BW'(kx)) * 22'sd5 - 22'sd589824)
                        : (22'sd983040 - signed'(MUL_BW'(kx)) * 22'sd3);
        w4 = prod_reg + (k_near ? KER_C_NEAR
                                : KER_C_FAR - signed'((MUL_PW'(kx) * 58'd24) << 32));
        w4_mag = w4[MUL_PW-1] ? MUL_PW'(-w4) : MUL_PW'(w4);
        w4_q   = (w4_mag + (58'd1 << 35)) >> 36;
        if (k_zero)
        begin
            k_weight = '0;
        end
        else
        begin
            k_weight = w4[MUL_PW-1] ? -signed'(WT_W'(w4_q)) : signed'(WT_W'(w4_q));
        end
    end

    // tap weight and address
    always_comb
    begin
        tp_mag = prod_reg[MUL_PW-1] ? MUL_PW'(-prod_reg) : MUL_PW'(prod_reg);
        tp_q   = (tp_mag + 58'd8192) >> 14;
        tap_w  = prod_reg[MUL_PW-1] ? -signed'(WT_W'(tp_q)) : signed'(WT_W'(tp_q));

        swd = signed'({2'b00, sw});
        shd = signed'({2'b00, sh});
        sx  = 11'(base_x_reg) + signed'({9'd0, tap_reg[1:0]}) - 11'sd1;
        sy  = 11'(base_y_reg) + signed'({9'd0, tap_reg[3:2]}) - 11'sd1;
        px  = (sx < 11'sd0) ? 9'd0 : (sx >= swd) ? sw - 9'd1 : sx[8:0];
        py  = (sy < 11'sd0) ? 9'd0 : (sy >= shd) ? sh - 9'd1 : sy[8:0];
        px12 = 12'(px);
        py12 = 12'(py);
        rd_addr = AW'(py12[RW-1:0] * MAX_SRC_WIDTH) + AW'(px12[CW-1:0]);

        pb = signed'({1'b0, rd_data_reg[7:0]});
        pg = signed'({1'b0, rd_data_reg[15:8]});
        pr = signed'({1'b0, rd_data_reg[23:16]});
    end

    // normalisation
    always_comb
    begin
        unique case (ch_reg)
            2'd0:    ch_sum = acc_b_reg;
            2'd1:    ch_sum = acc_g_reg;
            default: ch_sum = acc_r_reg;
        endcase
        den_eff = (acc_t_reg > 32'sd0) ? acc_t_reg : 32'sd16384;
        ch_mag  = ch_sum[31] ? 33'(-33'(ch_sum)) : 33'(ch_sum);
        if (ch_sum[31] || div_quo_reg == '0)
        begin
            ch_val = 8'd0;
        end
        else if (div_quo_reg >= DIV_NW'(255))
        begin
            ch_val = 8'd255;
        end
        else
        begin
            ch_val = div_quo_reg[7:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept && req_ok) state_next = ST_CRD_LOAD;
            ST_CRD_LOAD: state_next = ST_CRD_DIV;
            ST_CRD_DIV:  if (div_cnt_reg == DIV_LAST) state_next = ST_CRD_END;
            ST_CRD_END:  state_next = axis_reg ? ST_KER_SQR : ST_CRD_LOAD;
            ST_KER_SQR:  state_next = ST_KER_MUL;
            ST_KER_MUL:  state_next = ST_KER_RND;
            ST_KER_RND:  state_next = (k_reg == 3'd7) ? ST_TAP_MUL : ST_KER_SQR;
            ST_TAP_MUL:  state_next = ST_TAP_RND;
            ST_TAP_RND:  state_next = ST_TAP_ACC;
            ST_TAP_ACC:  state_next = (tap_reg == 4'd15) ? ST_FIN_LOAD : ST_TAP_MUL;
            ST_FIN_LOAD: state_next = ST_FIN_DIV;
            ST_FIN_DIV:  if (div_cnt_reg == DIV_LAST) state_next = ST_FIN_END;
            ST_FIN_END:  state_next = (ch_reg == 2'd2) ? ST_DONE : ST_FIN_LOAD;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        done = (state_reg == ST_DONE);
        result.out_col   = col_reg;
        result.out_row   = row_reg;
        result.blue_out  = blue_reg;
        result.green_out = green_reg;
        result.red_out   = red_reg;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                col_reg  <= item.col;
                row_reg  <= item.row;
                axis_reg <= 1'b0;
            end
            ST_CRD_LOAD:
            begin
                div_quo_reg <= {mul_p[21:0], 16'd0};
                div_den_reg <= DIV_DW'({ddim_sel, 1'b0});
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
            end
            ST_CRD_DIV, ST_FIN_DIV:
            begin
                div_rem_reg <= div_ok ? div_diff[DIV_DW-1:0]
                                      : {div_rem_reg[DIV_DW-2:0], div_quo_reg[DIV_NW-1]};
                div_quo_reg <= {div_quo_reg[DIV_NW-2:0], div_ok};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            ST_CRD_END:
            begin
                if (axis_reg)
                begin
                    base_y_reg <= crd_s[25:16];
                    u_y_reg    <= crd_s[15:0];
                end
                else
                begin
                    base_x_reg <= crd_s[25:16];
                    u_x_reg    <= crd_s[15:0];
                end
                axis_reg <= 1'b1;
                k_reg    <= '0;
            end
            ST_KER_SQR, ST_KER_MUL:
            begin
                prod_reg <= mul_p;
            end
            ST_KER_RND:
            begin
                if (k_reg[2])
                begin
                    wy_reg[k_reg[1:0]] <= k_weight;
                end
                else
                begin
                    wx_reg[k_reg[1:0]] <= k_weight;
                end
                k_reg     <= k_reg + 1'b1;
                tap_reg   <= '0;
                acc_b_reg <= '0;
                acc_g_reg <= '0;
                acc_r_reg <= '0;
                acc_t_reg <= '0;
            end
            ST_TAP_MUL:
            begin
                prod_reg <= mul_p;
            end
            ST_TAP_RND:
            begin
                w_reg <= tap_w;
            end
            ST_TAP_ACC:
            begin
                acc_b_reg <= acc_b_reg + pb * w_reg;
                acc_g_reg <= acc_g_reg + pg * w_reg;
                acc_r_reg <= acc_r_reg + pr * w_reg;
                acc_t_reg <= acc_t_reg + 32'(w_reg);
                tap_reg   <= tap_reg + 1'b1;
                ch_reg    <= '0;
            end
            ST_FIN_LOAD:
            begin
                div_quo_reg <= DIV_NW'({ch_mag, 1'b0}) + DIV_NW'(den_eff);
                div_den_reg <= {den_eff[DIV_DW-2:0], 1'b0};
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
            end
            ST_FIN_END:
            begin
                unique case (ch_reg)
                    2'd0:    blue_reg  <= ch_val;
                    2'd1:    green_reg <= ch_val;
                    default: red_reg   <= ch_val;
                endcase
                ch_reg <= ch_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    `include "bicubic_image_resizer_macros.svh"

    `BIR_ASSERT_NOW(a_done_busy, done, busy, "result beat outside a request")
    `BIR_ASSERT_NEXT(a_done_idle, done, !busy, "block not idle after result beat")
    `BIR_ASSERT_NEXT(a_write_fast, start && !busy && !item.mode, !busy, "pixel write held busy")
    `BIR_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start), "busy rose without a start")

endmodule

`default_nettype wire

### verif/tb_bicubic_image_resizer.sv
`timescale 1ns / 1ps

module tb_bicubic_image_resizer;

    import bir_pkg::*;

    localparam int unsigned SRC_MAX   = 256;
    localparam int unsigned DST_MAX   = 4096;
    localparam int unsigned SETTLE    = 300;
    localparam int unsigned MAX_CYCLE = 3000000;
    localparam int unsigned N_ITEMS   = 1800;

    class resize_scoreboard;
        bir_result_t    pending[$];
        bit [23:0]      pixels[int];
        int unsigned    src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
        int             errors;

        function new();
            src_w_reg = 256;
            src_h_reg = 256;
            dst_w_reg = 256;
            dst_h_reg = 256;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned v);
            case (idx)
                REG_SOURCE_WIDTH:  src_w_reg = v & 32'h1FF;
                REG_SOURCE_HEIGHT: src_h_reg = v & 32'h1FF;
                REG_TARGET_WIDTH:  dst_w_reg = v & 32'h1FFF;
                default:           dst_h_reg = v & 32'h1FFF;
            endcase
        endfunction

        function int unsigned eff_dim(int unsigned v, int unsigned lim);
            if (v == 0)
                return 1;
            return (v > lim) ? lim : v;
        endfunction

        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (2 * mag + den) / (2 * den);
            return (num < 0) ? -q : q;
        endfunction

        // Keys kernel, t in Q.16, weight in Q2.14
        function int keys_weight(longint t);
            longint x, x2, x3, w4;
            longint one;
            one = 65536;
            x = (t < 0) ? -t : t;
            x2 = x * x;
            x3 = x2 * x;
            if (x <= one)
                w4 = 5 * x3 - 9 * x2 * one + 4 * one * one * one;
            else if (x < 2 * one)
                w4 = -3 * x3 + 15 * x2 * one - 24 * x * one * one + 12 * one * one * one;
            else
                return 0;
            return int'(round_div(w4, longint'(1) << 36));
        endfunction

        function void axis(int unsigned dst, int unsigned sdim, int unsigned ddim,
                           output int unsigned idx[4], output int w[4]);
            longint num, s, u, base, p;
            num = (2 * longint'(dst) + 1) * longint'(sdim) * 65536;
            s = num / (2 * longint'(ddim)) - 32768;
            u = s & 64'hFFFF;
            base = (s - u) / 65536;
            for (int n = -1; n <= 2; n++)
            begin
                p = base + n;
                if (p < 0)
                    p = 0;
                if (p >= sdim)
                    p = sdim - 1;
                idx[n + 1] = p;
                w[n + 1] = keys_weight(u - longint'(n) * 65536);
            end
        endfunction

        function logic [7:0] to_byte(int sum, int total);
            longint v;
            if (total > 0)
                v = round_div(sum, total);
            else
                v = round_div(sum, 16384);
            if (v <= 0)
                return 8'd0;
            if (v >= 255)
                return 8'd255;
            return v[7:0];
        endfunction

        function void note_item(bir_item_t it);
            int unsigned sw, sh, tw, th;
            int unsigned px[4], py[4];
            int wx[4], wy[4];
            int sb, sg, sr, total, w;
            bit [23:0] pix;
            bir_result_t r;
            sw = eff_dim(src_w_reg, SRC_MAX);
            sh = eff_dim(src_h_reg, SRC_MAX);
            tw = eff_dim(dst_w_reg, DST_MAX);
            th = eff_dim(dst_h_reg, DST_MAX);
            if (it.mode == 1'b0)
            begin
                if (it.col < sw && it.row < sh)
                    pixels[it.row * SRC_MAX + it.col] = {it.red_in, it.green_in, it.blue_in};
                return;
            end
            if (it.col >= tw || it.row >= th)
                return;
            axis(it.col, sw, tw, px, wx);
            axis(it.row, sh, th, py, wy);
            sb = 0;
            sg = 0;
            sr = 0;
            total = 0;
            for (int m = 0; m < 4; m++)
            begin
                for (int n = 0; n < 4; n++)
                begin
                    w = int'(round_div(longint'(wx[n]) * wy[m], 16384));
                    pix = pixels.exists(py[m] * SRC_MAX + px[n]) ?
                          pixels[py[m] * SRC_MAX + px[n]] : 24'd0;
                    sb += int'(pix[7:0]) * w;
                    sg += int'(pix[15:8]) * w;
                    sr += int'(pix[23:16]) * w;
                    total += w;
                end
            end
            r.out_col   = it.col;
            r.out_row   = it.row;
            r.blue_out  = to_byte(sb, total);
            r.green_out = to_byte(sg, total);
            r.red_out   = to_byte(sr, total);
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $time, msg);
            errors++;
        endtask

        task check(bir_result_t got);
            bir_result_t exp_r;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp_r = pending.pop_front();
            if (got.out_col !== exp_r.out_col)
                report($sformatf("out_col %0d, want %0d", got.out_col, exp_r.out_col));
            if (got.out_row !== exp_r.out_row)
                report($sformatf("out_row %0d, want %0d", got.out_row, exp_r.out_row));
            if (got.blue_out !== exp_r.blue_out)
                report($sformatf("blue %0d, want %0d at (%0d,%0d)", got.blue_out,
                                 exp_r.blue_out, exp_r.out_col, exp_r.out_row));
            if (got.green_out !== exp_r.green_out)
                report($sformatf("green %0d, want %0d at (%0d,%0d)", got.green_out,
                                 exp_r.green_out, exp_r.out_col, exp_r.out_row));
            if (got.red_out !== exp_r.red_out)
                report($sformatf("red %0d, want %0d at (%0d,%0d)", got.red_out,
                                 exp_r.red_out, exp_r.out_col, exp_r.out_row));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    bir_item_t   item;
    logic        done;
    bir_result_t result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    resize_scoreboard sb;
    bit          written[SRC_MAX * SRC_MAX];
    int unsigned idle_pct;
    int unsigned accepted;
    longint      cycles;

    bicubic_image_resizer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function int unsigned src_w();
        return sb.eff_dim(sb.src_w_reg, SRC_MAX);
    endfunction

    function int unsigned src_h();
        return sb.eff_dim(sb.src_h_reg, SRC_MAX);
    endfunction

    function int unsigned dst_w();
        return sb.eff_dim(sb.dst_w_reg, DST_MAX);
    endfunction

    function int unsigned dst_h();
        return sb.eff_dim(sb.dst_h_reg, DST_MAX);
    endfunction

    // called at a falling edge; returns at a falling edge
    task send_beat(bir_item_t it);
        start <= 1'b1;
        item  <= it;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_item(it);
        accepted++;
        if (it.mode == 1'b0 && it.col < src_w() && it.row < src_h())
            written[it.row * SRC_MAX + it.col] = 1'b1;
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task drain();
        start <= 1'b0;
        while (sb.pending.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task write_reg(logic [1:0] idx, int unsigned v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task set_geometry(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
        drain();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_TARGET_WIDTH, tw);
        write_reg(REG_TARGET_HEIGHT, th);
    endtask

    function bit [7:0] rand_byte();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function bir_item_t pixel_write(int unsigned c, int unsigned r);
        bir_item_t it;
        it.mode     = 1'b0;
        it.col      = c;
        it.row      = r;
        it.blue_in  = rand_byte();
        it.green_in = rand_byte();
        it.red_in   = rand_byte();
        return it;
    endfunction

    function bir_item_t pixel_request(int unsigned c, int unsigned r);
        bir_item_t it;
        it = $urandom;
        it.mode = 1'b1;
        it.col  = c;
        it.row  = r;
        return it;
    endfunction

    // every source pixel inside the image must hold data before a request
    task fill_source();
        for (int unsigned r = 0; r < src_h(); r++)
            for (int unsigned c = 0; c < src_w(); c++)
                if (!written[r * SRC_MAX + c])
                    send_beat(pixel_write(c, r));
    endtask

    task random_beat();
        bir_item_t it;
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 50)
        begin
            it = pixel_request($urandom_range(0, dst_w() - 1), $urandom_range(0, dst_h() - 1));
        end
        else if (k < 80)
        begin
            it = pixel_write($urandom_range(0, src_w() - 1), $urandom_range(0, src_h() - 1));
        end
        else if (k < 88)
        begin
            it = pixel_request($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
        else if (k < 96)
        begin
            it = pixel_write($urandom_range(0, 4095), $urandom_range(0, 4095));
            if ($urandom_range(0, 1))
                it.col = $urandom_range(src_w(), 4095);
            else
                it.row = $urandom_range(src_h(), 4095);
        end
        else
        begin
            it = $urandom;
            it.mode = 1'b1;
        end
        send_beat(it);
    endtask

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct = 0;
        accepted = 0;
        cycles   = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // upscale to the largest target, corners
        set_geometry(4, 4, 4096, 4096);
        fill_source();
        send_beat(pixel_request(0, 0));
        send_beat(pixel_request(4095, 4095));
        send_beat(pixel_request(4095, 0));
        send_beat(pixel_request(0, 4095));
        send_beat(pixel_request(2047, 2048));
        send_beat(pixel_write(4, 0));
        send_beat(pixel_write(4095, 4095));
        send_beat(pixel_request(1, 3000));

        // zero registers count as one
        set_geometry(0, 0, 0, 0);
        fill_source();
        send_beat(pixel_request(0, 0));
        send_beat(pixel_request(1, 0));
        send_beat(pixel_request(0, 1));

        // oversize values saturate
        set_geometry(511, 2, 8191, 0);
        fill_source();
        send_beat(pixel_request(4095, 0));
        send_beat(pixel_request(0, 0));
        send_beat(pixel_request(1234, 0));

        // strong downscale, then upscale from a narrow source
        set_geometry(256, 3, 1, 1);
        fill_source();
        send_beat(pixel_request(0, 0));
        set_geometry(2, 256, 3, 300);
        fill_source();
        send_beat(pixel_request(2, 299));
        send_beat(pixel_request(0, 0));
        send_beat(pixel_request(3, 0));

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 12 : (ph == 1) ? 61 : 0;
            while (accepted < N_ITEMS * (ph + 1) / 3)
            begin
                if ($urandom_range(0, 7) == 0)
                    set_geometry($urandom_range(0, 1) ? 0 : 300, $urandom_range(1, 3),
                                 $urandom_range(0, 1) ? 4096 : 1, $urandom_range(1, 64));
                else
                    set_geometry($urandom_range(1, 20), $urandom_range(1, 20),
                                 $urandom_range(1, 64), $urandom_range(1, 64));
                fill_source();
                repeat ($urandom_range(20, 60))
                    random_beat();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/bir_pkg.sv
src/bicubic_image_resizer.sv
verif/tb_bicubic_image_resizer.sv
